// ===== hw/rtl/uer_pkg.sv =====
`timescale 1ns / 1ps
// uer_pkg: shared constants, codes and types for the ultrasonic echo ranger
// depends on nothing; imported by ultrasonic_echo_ranger, ranger_checker and testbench

package uer_pkg;

  // echo count width and derived widths
  localparam int COUNT_BITS  = 16;
  localparam int TICK_W      = (COUNT_BITS > 17) ? COUNT_BITS : 17;
  localparam int DIST_W      = 11;
  localparam int DIST_EXT_W  = (COUNT_BITS > DIST_W) ? COUNT_BITS : DIST_W;
  localparam int SCALE_W     = 16;
  localparam int PROD_W      = COUNT_BITS + SCALE_W;
  localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int DIST_MAX    = (1 << DIST_W) - 1;

  // register file layout
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int HOLD_W      = 17;

  localparam logic [CFG_IDX_W-1:0] REG_TRIG_TICKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WAIT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CYCLES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q16      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_NORMAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_NEAR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT     = 3'd6;

  // register reset values
  localparam logic [7:0]        RST_TRIG_TICKS     = 8'd20;
  localparam logic [15:0]       RST_MAX_WAIT       = 16'd21684;
  localparam logic [15:0]       RST_MIN_CYCLES     = 16'd109;
  localparam logic [15:0]       RST_SCALE_Q16      = 16'd1209;
  localparam logic [HOLD_W-1:0] RST_HOLDOFF_NORMAL = 17'd65536;
  localparam logic [HOLD_W-1:0] RST_HOLDOFF_NEAR   = 17'd9216;
  localparam logic [DIST_W-1:0] RST_NEAR_LIMIT     = 11'd10;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEAR = 2'd1,
    ST_FAR  = 2'd2
  } status_t;

  // stream word widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // one result word, lowest field last in the struct
  typedef struct packed {
    logic              busy_res;
    logic              refused;
    logic              near;
    logic              changed;
    logic [DIST_W-1:0] distance_cm;
    status_t           status;
    logic              done_res;
    logic              trigger;
  } result_t;

endpackage

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
`timescale 1ns / 1ps
// ultrasonic_echo_ranger: per-tick trigger/echo controller for a range sensor
// depends on uer_pkg

// One input word is one timer tick (bit 0 start_req, bit 1 echo) and gives
// exactly one result word. A word is taken every clock while m_axis_tready is
// high: the tick is decoded against the phase state in one pass and its result
// lands in the output register in the cycle after acceptance; a new tick is
// accepted in the same cycle the previous result is taken, so the sustained rate
// is one tick per clock while m_axis_tready is high. The longest path is the
// 16x16 echo-count times scale multiply followed by saturation and the compare
// against the last distance. Configuration writes take effect on the next
// accepted tick.
module ultrasonic_echo_ranger (
  input  logic                          clk,
  input  logic                          rst,
  // tick input: [0] start_req, [1] echo, [7:2] zero
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [uer_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // result output: [0] trigger, [1] done_res, [3:2] status, [14:4] distance_cm,
  // [15] changed, [16] near, [17] refused, [18] busy_res, [23:19] zero
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [uer_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
  import uer_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TRIG  = 3'd1,
    PH_WAIT  = 3'd2,
    PH_COUNT = 3'd3,
    PH_HOLD  = 3'd4
  } phase_t;

  // configuration registers
  logic [7:0]        trig_ticks;
  logic [15:0]       max_wait;
  logic [15:0]       min_cycles;
  logic [SCALE_W-1:0] scale_q16;
  logic [HOLD_W-1:0] holdoff_normal;
  logic [HOLD_W-1:0] holdoff_near;
  logic [DIST_W-1:0] near_limit;

  // measurement state
  phase_t            phase, phase_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [DIST_W-1:0] last_distance, last_distance_next;
  logic [DIST_W-1:0] reported_distance, reported_distance_next;
  status_t           last_status, last_status_next;

  // output register
  logic              out_valid;
  result_t           out_word;
  result_t           res;

  logic              in_accept;
  logic              start_req;
  logic              echo;

  logic [PROD_W-1:0]     prod;
  logic [COUNT_BITS-1:0] dist_raw;
  logic [DIST_EXT_W-1:0] dist_wide;
  logic [DIST_W-1:0]     dist_sat;
  logic [TICK_W-1:0]     tick_inc;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign start_req     = s_axis_tdata[0];
  assign echo          = s_axis_tdata[1];

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'(out_word);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_ticks     <= RST_TRIG_TICKS;
      max_wait       <= RST_MAX_WAIT;
      min_cycles     <= RST_MIN_CYCLES;
      scale_q16      <= RST_SCALE_Q16;
      holdoff_normal <= RST_HOLDOFF_NORMAL;
      holdoff_near   <= RST_HOLDOFF_NEAR;
      near_limit     <= RST_NEAR_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TRIG_TICKS:     trig_ticks     <= cfg_data[7:0];
        REG_MAX_WAIT:       max_wait       <= cfg_data[15:0];
        REG_MIN_CYCLES:     min_cycles     <= cfg_data[15:0];
        REG_SCALE_Q16:      scale_q16      <= cfg_data[SCALE_W-1:0];
        REG_HOLDOFF_NORMAL: holdoff_normal <= cfg_data[HOLD_W-1:0];
        REG_HOLDOFF_NEAR:   holdoff_near   <= cfg_data[HOLD_W-1:0];
        REG_NEAR_LIMIT:     near_limit     <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // echo length to centimetres, saturated to the distance range
  assign prod      = PROD_W'(tick_count[COUNT_BITS-1:0]) * PROD_W'(scale_q16);
  assign dist_raw  = prod[PROD_W-1:SCALE_W];
  assign dist_wide = DIST_EXT_W'(dist_raw);
  assign dist_sat  = (dist_wide > DIST_EXT_W'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                          : dist_wide[DIST_W-1:0];
  assign tick_inc  = tick_count + TICK_W'(1);

  // next state and result word for one tick
  always_comb begin
    phase_next             = phase;
    tick_count_next        = tick_count;
    last_distance_next     = last_distance;
    reported_distance_next = reported_distance;
    last_status_next       = last_status;
    res                    = '0;

    case (phase)
      PH_TRIG: begin
        res.trigger     = 1'b1;
        tick_count_next = tick_inc;
        if (tick_inc >= TICK_W'(trig_ticks)) begin
          phase_next      = PH_WAIT;
          tick_count_next = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          phase_next      = PH_COUNT;
          tick_count_next = TICK_W'(1);
        end else begin
          tick_count_next = tick_inc;
          if (tick_inc >= TICK_W'(max_wait)) begin
            res.done_res     = 1'b1;
            last_status_next = ST_FAR;
            phase_next       = PH_IDLE;
            tick_count_next  = '0;
          end
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (tick_count < TICK_W'(COUNT_MAX)) begin
            tick_count_next = tick_inc;
          end
        end else begin
          res.done_res = 1'b1;
          phase_next   = PH_HOLD;
          if (tick_count <= TICK_W'(min_cycles)) begin
            last_status_next = ST_NEAR;
            tick_count_next  = TICK_W'(holdoff_near);
          end else begin
            last_status_next       = ST_OK;
            reported_distance_next = dist_sat;
            tick_count_next        = TICK_W'(holdoff_normal);
            if (dist_sat != last_distance) begin
              res.changed        = 1'b1;
              last_distance_next = dist_sat;
              res.near           = (dist_sat < near_limit);
            end
          end
        end
      end
      PH_HOLD: begin
        res.refused = start_req;
        if (tick_count <= TICK_W'(1)) begin
          tick_count_next = '0;
          phase_next      = PH_IDLE;
        end else begin
          tick_count_next = tick_count - TICK_W'(1);
        end
      end
      default: begin
        // idle and unused codes
        phase_next = PH_IDLE;
        if (start_req) begin
          res.trigger     = 1'b1;
          tick_count_next = TICK_W'(1);
          phase_next      = PH_TRIG;
          if (TICK_W'(1) >= TICK_W'(trig_ticks)) begin
            phase_next      = PH_WAIT;
            tick_count_next = '0;
          end
        end
      end
    endcase

    res.status      = last_status_next;
    res.distance_cm = reported_distance_next;
    res.busy_res    = (phase_next != PH_IDLE);
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      tick_count        <= '0;
      last_distance     <= '0;
      reported_distance <= '0;
      last_status       <= ST_OK;
      out_valid         <= 1'b0;
    end else begin
      if (in_accept) begin
        phase             <= phase_next;
        tick_count        <= tick_count_next;
        last_distance     <= last_distance_next;
        reported_distance <= reported_distance_next;
        last_status       <= last_status_next;
        out_valid         <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_accept) begin
      out_word <= res;
    end
  end

  // near distance only reported together with a change
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.near |-> out_word.changed)
    else $error("near flagged without changed distance");

  // a finished ok or too-near measurement always enters holdoff
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.done_res && (out_word.status != ST_FAR) |-> out_word.busy_res)
    else $error("measurement finished without holdoff");

  // a refused start never drives the trigger or a result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.refused |-> !out_word.trigger && !out_word.done_res)
    else $error("refused start produced trigger or result");

  // trigger count never exceeds the 8-bit trigger length
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_TRIG |-> tick_count < TICK_W'(256))
    else $error("trigger count out of range");

  // state only moves on an accepted tick
  assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(phase) && $stable(tick_count))
    else $error("state changed without an accepted tick");

endmodule

// ===== tb/sv/ranger_checker.sv =====
`timescale 1ns / 1ps
// ranger_checker: watches the tick, result and register channels of the ranger,
// predicts every result word and compares it field by field; depends on uer_pkg

module ranger_checker
  import uer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  input  logic                  s_ready,
  input  logic [IN_DATA_W-1:0]  s_data,
  input  logic                  m_valid,
  input  logic                  m_ready,
  input  logic [OUT_DATA_W-1:0] m_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output logic                  meas_busy,
  output int                    words_checked,
  output int                    n_ok,
  output int                    n_near,
  output int                    n_far
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TRIG  = 3'd1,
    PH_WAIT  = 3'd2,
    PH_COUNT = 3'd3,
    PH_HOLD  = 3'd4
  } meas_phase_t;

  // register copies
  logic [7:0]        trig_ticks_r;
  logic [15:0]       max_wait_r;
  logic [15:0]       min_cycles_r;
  logic [SCALE_W-1:0] scale_r;
  logic [HOLD_W-1:0] hold_normal_r;
  logic [HOLD_W-1:0] hold_near_r;
  logic [DIST_W-1:0] near_lim_r;

  // measurement state
  meas_phase_t       meas_phase;
  logic [TICK_W-1:0] tick;
  logic [DIST_W-1:0] last_dist;
  logic [DIST_W-1:0] rep_dist;
  status_t           stat;

  result_t tick_results_due[$];
  int errs    = 0;
  int checked = 0;
  int oks     = 0;
  int nears   = 0;
  int fars    = 0;

  function automatic void reset_ranger();
    trig_ticks_r  = RST_TRIG_TICKS;
    max_wait_r    = RST_MAX_WAIT;
    min_cycles_r  = RST_MIN_CYCLES;
    scale_r       = RST_SCALE_Q16;
    hold_normal_r = RST_HOLDOFF_NORMAL;
    hold_near_r   = RST_HOLDOFF_NEAR;
    near_lim_r    = RST_NEAR_LIMIT;
    meas_phase    = PH_IDLE;
    tick          = '0;
    last_dist     = '0;
    rep_dist      = '0;
    stat          = ST_OK;
  endfunction

  function automatic void take_register(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_TRIG_TICKS:     trig_ticks_r  = val[7:0];
      REG_MAX_WAIT:       max_wait_r    = val[15:0];
      REG_MIN_CYCLES:     min_cycles_r  = val[15:0];
      REG_SCALE_Q16:      scale_r       = val[SCALE_W-1:0];
      REG_HOLDOFF_NORMAL: hold_normal_r = val[HOLD_W-1:0];
      REG_HOLDOFF_NEAR:   hold_near_r   = val[HOLD_W-1:0];
      REG_NEAR_LIMIT:     near_lim_r    = val[DIST_W-1:0];
      default: ;
    endcase
  endfunction

  // advance the measurement by one tick and form its result word
  function automatic result_t next_tick_result(input logic st, input logic ec);
    result_t                   r;
    logic [PROD_W-1:0]         prod;
    logic [PROD_W-SCALE_W-1:0] dq;
    logic [DIST_W-1:0]         dist_cm;
    r = '0;
    case (meas_phase)
      PH_TRIG: begin
        r.trigger = 1'b1;
        tick = tick + TICK_W'(1);
        if (tick >= TICK_W'(trig_ticks_r)) begin
          meas_phase = PH_WAIT;
          tick = '0;
        end
      end
      PH_WAIT: begin
        if (ec) begin
          meas_phase = PH_COUNT;
          tick = TICK_W'(1);
        end else begin
          tick = tick + TICK_W'(1);
          // no echo in time: out of range, straight back to idle
          if (tick >= TICK_W'(max_wait_r)) begin
            r.done_res = 1'b1;
            stat = ST_FAR;
            meas_phase = PH_IDLE;
            tick = '0;
          end
        end
      end
      PH_COUNT: begin
        if (ec) begin
          if (tick < TICK_W'(COUNT_MAX)) tick = tick + TICK_W'(1);
        end else begin
          r.done_res = 1'b1;
          if (tick <= TICK_W'(min_cycles_r)) begin
            stat = ST_NEAR;
            tick = hold_near_r;
          end else begin
            prod    = PROD_W'(tick) * PROD_W'(scale_r);
            dq      = prod[PROD_W-1:SCALE_W];
            dist_cm = (dq > (PROD_W-SCALE_W)'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                        : dq[DIST_W-1:0];
            stat = ST_OK;
            rep_dist = dist_cm;
            if (dist_cm != last_dist) begin
              r.changed = 1'b1;
              last_dist = dist_cm;
              if (dist_cm < near_lim_r) r.near = 1'b1;
            end
            tick = hold_normal_r;
          end
          meas_phase = PH_HOLD;
        end
      end
      PH_HOLD: begin
        if (st) r.refused = 1'b1;
        if (tick <= TICK_W'(1)) begin
          tick = '0;
          meas_phase = PH_IDLE;
        end else begin
          tick = tick - TICK_W'(1);
        end
      end
      default: begin
        meas_phase = PH_IDLE;
        if (st) begin
          r.trigger = 1'b1;
          tick = TICK_W'(1);
          meas_phase = PH_TRIG;
          if (tick >= TICK_W'(trig_ticks_r)) begin
            meas_phase = PH_WAIT;
            tick = '0;
          end
        end
      end
    endcase
    r.status      = stat;
    r.distance_cm = rep_dist;
    r.busy_res    = (meas_phase != PH_IDLE);
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      errs++;
    end
  endtask

  // one pass per clock: registers, then the tick word, then the result word
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      reset_ranger();
      tick_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) take_register(cfg_index, cfg_data);
      if (s_valid && s_ready) begin
        want = next_tick_result(s_data[0], s_data[1]);
        if (want.done_res) begin
          case (want.status)
            ST_OK:   oks++;
            ST_NEAR: nears++;
            default: fars++;
          endcase
        end
        tick_results_due.push_back(want);
      end
      if (m_valid && m_ready) begin
        if (tick_results_due.size() == 0) begin
          $error("result word with no tick waiting for it: %h", m_data);
          errs++;
        end else begin
          want = tick_results_due.pop_front();
          got  = result_t'(m_data[$bits(result_t)-1:0]);
          check_field("trigger",     16'(want.trigger),     16'(got.trigger));
          check_field("done_res",    16'(want.done_res),    16'(got.done_res));
          check_field("status",      16'(want.status),      16'(got.status));
          check_field("distance_cm", 16'(want.distance_cm), 16'(got.distance_cm));
          check_field("changed",     16'(want.changed),     16'(got.changed));
          check_field("near",        16'(want.near),        16'(got.near));
          check_field("refused",     16'(want.refused),     16'(got.refused));
          check_field("busy_res",    16'(want.busy_res),    16'(got.busy_res));
          check_field("pad", 16'(0), 16'(m_data[OUT_DATA_W-1:$bits(result_t)]));
          checked++;
        end
      end
    end
    fail_count    <= errs;
    pending       <= tick_results_due.size();
    meas_busy     <= (meas_phase != PH_IDLE);
    words_checked <= checked;
    n_ok          <= oks;
    n_near        <= nears;
    n_far         <= fars;
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives ticks, register writes and output back-pressure into the
// ultrasonic echo ranger and gives the verdict; depends on uer_pkg, ultrasonic_echo_ranger, ranger_checker

module testbench;
  import uer_pkg::*;

  // well above the slowest legal run
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [7:0]        trig_ticks;
    logic [15:0]       max_wait;
    logic [15:0]       min_cycles;
    logic [15:0]       scale_q16;
    logic [HOLD_W-1:0] holdoff_normal;
    logic [HOLD_W-1:0] holdoff_near;
    logic [DIST_W-1:0] near_limit;
  } range_cfg_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int   fail_count;
  int   pending;
  logic meas_busy;
  int   words_checked;
  int   n_ok;
  int   n_near;
  int   n_far;

  int          cycle_count = 0;
  int          ticks_sent  = 0;
  int          settings_cnt = 0;
  int          gap_pct = 25;
  range_cfg_t  cur;

  always #6 clk = ~clk;

  ultrasonic_echo_ranger u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ranger_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_valid       (s_axis_tvalid),
    .s_ready       (s_axis_tready),
    .s_data        (s_axis_tdata),
    .m_valid       (m_axis_tvalid),
    .m_ready       (m_axis_tready),
    .m_data        (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .meas_busy     (meas_busy),
    .words_checked (words_checked),
    .n_ok          (n_ok),
    .n_near        (n_near),
    .n_far         (n_far)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("ultrasonic_echo_ranger regression: fail");
      $finish;
    end
  end

  // result side pacing: short stalls, rare long ones, calm stretches, and a
  // periodic long hold-off so the block backs up into its input
  int unsigned stall_left;
  int unsigned calm_left;
  int unsigned press_in;
  always @(posedge clk) begin : sink_pacing
    int unsigned roll;
    roll = $urandom_range(0, 999);
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      calm_left     <= 0;
      press_in      <= 600;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (press_in == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(200, 400);
      press_in      <= $urandom_range(1500, 3000);
    end else begin
      press_in <= press_in - 1;
      if (calm_left != 0) begin
        m_axis_tready <= 1'b1;
        calm_left     <= calm_left - 1;
      end else if (roll < 5) begin
        m_axis_tready <= 1'b1;
        calm_left     <= $urandom_range(100, 600);
      end else if (roll < 850) begin
        m_axis_tready <= 1'b1;
      end else if (roll < 995) begin
        m_axis_tready <= 1'b0;
        stall_left    <= $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        stall_left    <= $urandom_range(8, 40);
      end
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // offer one tick word, after an optional gap, and wait until it is taken
  task automatic send_tick(input logic st, input logic ec);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_DATA_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({ec, st});
    do @(posedge clk); while (!s_axis_tready);
    ticks_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input range_cfg_t c);
    write_reg(REG_TRIG_TICKS,     CFG_DATA_W'(c.trig_ticks));
    write_reg(REG_MAX_WAIT,       CFG_DATA_W'(c.max_wait));
    write_reg(REG_MIN_CYCLES,     CFG_DATA_W'(c.min_cycles));
    write_reg(REG_SCALE_Q16,      CFG_DATA_W'(c.scale_q16));
    write_reg(REG_HOLDOFF_NORMAL, CFG_DATA_W'(c.holdoff_normal));
    write_reg(REG_HOLDOFF_NEAR,   CFG_DATA_W'(c.holdoff_near));
    write_reg(REG_NEAR_LIMIT,     CFG_DATA_W'(c.near_limit));
    cfg_valid <= 1'b0;
    cur = c;
    settings_cnt++;
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // start from idle, trigger, wait and the high part of the echo pulse;
  // delay at or past max_wait ends in a timeout instead
  task automatic echo_start(input int unsigned delay, input int unsigned len);
    int unsigned trig_n;
    int unsigned mw_n;
    int unsigned n;
    trig_n = (cur.trig_ticks == 0) ? 1 : cur.trig_ticks;
    mw_n   = (cur.max_wait == 0) ? 1 : cur.max_wait;
    send_tick(1'b1, coin());
    for (n = 1; n < trig_n; n++) send_tick(coin(), coin());
    for (n = 0; n < delay && n < mw_n; n++) send_tick(coin(), 1'b0);
    if (delay >= mw_n) return;
    for (n = 0; n < len; n++) send_tick(coin(), 1'b1);
  endtask

  // falling echo edge and the whole holdoff after it
  task automatic echo_finish(input int unsigned len);
    int unsigned hold_n;
    int unsigned cnt;
    int unsigned n;
    send_tick(coin(), 1'b0);
    cnt    = (len > COUNT_MAX) ? COUNT_MAX : len;
    hold_n = (cnt <= cur.min_cycles) ? cur.holdoff_near : cur.holdoff_normal;
    if (hold_n == 0) hold_n = 1;
    // starts land all through the holdoff, the last tick included
    for (n = 0; n < hold_n; n++) send_tick(coin(), coin());
  endtask

  // one full measurement from idle: start, trigger, wait, echo pulse, holdoff
  task automatic range_once(input int unsigned delay, input int unsigned len);
    int unsigned mw_n;
    mw_n = (cur.max_wait == 0) ? 1 : cur.max_wait;
    echo_start(delay, len);
    if (delay < mw_n) echo_finish(len);
  endtask

  // random start and echo levels, then quiet ticks until the block is idle
  task automatic echo_noise(input int unsigned len);
    int unsigned n;
    for (n = 0; n < len; n++) send_tick(coin(), coin());
    do send_tick(1'b0, 1'b0); while (meas_busy);
  endtask

  function automatic range_cfg_t random_settings();
    range_cfg_t  c;
    int unsigned roll;
    c.trig_ticks     = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
    c.max_wait       = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 40));
    c.min_cycles     = 16'($urandom_range(0, 20));
    roll = $urandom_range(0, 99);
    c.scale_q16      = (roll < 15) ? 16'd0 : ((roll < 30) ? 16'hFFFF : 16'($urandom));
    c.holdoff_normal = ($urandom_range(0, 9) == 0) ? '0 : HOLD_W'($urandom_range(1, 10));
    c.holdoff_near   = ($urandom_range(0, 9) == 0) ? '0 : HOLD_W'($urandom_range(1, 10));
    roll = $urandom_range(0, 99);
    c.near_limit     = (roll < 10) ? '0 : ((roll < 20) ? DIST_W'(1209)
                                                       : DIST_W'($urandom_range(0, 1209)));
    return c;
  endfunction

  initial begin : stimulus
    range_cfg_t  c;
    int unsigned mw_n;
    int unsigned delay;
    int unsigned len;
    int unsigned last_len;
    int          p;
    int          phase_start;

    cur.trig_ticks     = RST_TRIG_TICKS;
    cur.max_wait       = RST_MAX_WAIT;
    cur.min_cycles     = RST_MIN_CYCLES;
    cur.scale_q16      = RST_SCALE_Q16;
    cur.holdoff_normal = RST_HOLDOFF_NORMAL;
    cur.holdoff_near   = RST_HOLDOFF_NEAR;
    cur.near_limit     = RST_NEAR_LIMIT;
    last_len = 1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: trigger length, counting and scaling with the reset
    // values; each holdoff is cut short while the echo is still high
    gap_pct = 2;
    echo_start(5, 300);
    drain();
    write_reg(REG_HOLDOFF_NORMAL, CFG_DATA_W'(4));
    cfg_valid <= 1'b0;
    cur.holdoff_normal = HOLD_W'(4);
    echo_finish(300);
    echo_start(3, 50);
    drain();
    write_reg(REG_HOLDOFF_NEAR, CFG_DATA_W'(3));
    cfg_valid <= 1'b0;
    cur.holdoff_near = HOLD_W'(3);
    echo_finish(50);
    drain();

    // zero trigger, zero wait, zero holdoffs, full scale
    c.trig_ticks = 8'd0; c.max_wait = 16'd0; c.min_cycles = 16'd2;
    c.scale_q16 = 16'hFFFF; c.holdoff_normal = '0; c.holdoff_near = '0;
    c.near_limit = DIST_W'(1209);
    load_settings(c);
    gap_pct = 20;
    range_once(0, 2);
    range_once(0, 3);
    range_once(0, 100);
    range_once(0, 100);
    range_once(1, 1);
    echo_noise(8);
    drain();

    // largest trigger, every count too near
    c.trig_ticks = 8'd255; c.max_wait = 16'd300; c.min_cycles = 16'hFFFF;
    c.scale_q16 = 16'hFFFF; c.holdoff_normal = HOLD_W'(65536); c.holdoff_near = HOLD_W'(1);
    c.near_limit = '0;
    load_settings(c);
    gap_pct = 2;
    range_once(2, 40);
    drain();

    // random settings with mostly well-formed measurements, some noise
    for (int ph = 0; ph < 4; ph++) begin
      load_settings(random_settings());
      gap_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 12 : 35);
      mw_n = (cur.max_wait == 0) ? 1 : cur.max_wait;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < 225) begin
        p = $urandom_range(0, 99);
        if (p < 75) begin
          delay = ($urandom_range(0, 6) == 0) ? mw_n : $urandom_range(0, mw_n - 1);
          if ($urandom_range(0, 6) == 0)
            len = last_len;
          else if ($urandom_range(0, 2) == 0)
            len = $urandom_range(1, (cur.min_cycles == 0) ? 1 : cur.min_cycles);
          else
            len = $urandom_range(cur.min_cycles + 1, cur.min_cycles + 60);
          last_len = len;
          range_once(delay, len);
        end else begin
          echo_noise($urandom_range(1, 12));
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d ticks over %0d register settings, %0d result words checked",
             ticks_sent, settings_cnt + 1, words_checked);
    $display("measurements finished: %0d ok, %0d too near, %0d out of range",
             n_ok, n_near, n_far);
    if (fail_count == 0) begin
      $display("ultrasonic_echo_ranger regression: pass");
    end else begin
      $display("ultrasonic_echo_ranger regression: fail");
    end
    $finish;
  end

endmodule
